FILE: sv/sync_serial_frame_codec_top_assert.svh
// Assertion macros for the serial frame codec.
`ifndef SYNC_SERIAL_FRAME_CODEC_TOP_ASSERT_SVH
`define SYNC_SERIAL_FRAME_CODEC_TOP_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define SSFC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssfc assertion failed");

// Check a consequent in the cycle after its antecedent.
`define SSFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssfc assertion failed");

`endif

FILE: sv/ssfc_pkg.sv
// Types, codes and helpers shared by the serial frame codec.
`timescale 1ns / 1ps

package ssfc_pkg;

  // Command codes
  localparam logic [1:0] CMD_IDLE  = 2'd0;
  localparam logic [1:0] CMD_FRAME = 2'd1;
  localparam logic [1:0] CMD_RECV  = 2'd2;

  // Receive status codes
  localparam logic [2:0] ST_BUSY    = 3'd0;
  localparam logic [2:0] ST_OK      = 3'd1;
  localparam logic [2:0] ST_PARITY  = 3'd2;
  localparam logic [2:0] ST_FRAMING = 3'd3;
  localparam logic [2:0] ST_TIMEOUT = 3'd4;

  // Receiver phases: hunt, data bits 1..8, parity, first stop, second stop
  localparam logic [3:0] PH_HUNT   = 4'd0;
  localparam logic [3:0] PH_DATA1  = 4'd1;
  localparam logic [3:0] PH_DATA8  = 4'd8;
  localparam logic [3:0] PH_PARITY = 4'd9;
  localparam logic [3:0] PH_STOP1  = 4'd10;
  localparam logic [3:0] PH_STOP2  = 4'd11;

  localparam logic [7:0] HUNT_LIMIT_RESET = 8'd64;
  localparam logic [5:0] MAX_IDLE         = 6'd32;
  localparam logic [4:0] FRAME_LAST_POS   = 5'd11;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] tx_data;
    logic [5:0] idle_bits;
    logic       line_sample;
  } ssfc_in_t;

  typedef struct packed {
    logic       bit_valid;
    logic       line_bit;
    logic [2:0] rx_status;
    logic [7:0] rx_data;
    logic       last;
  } ssfc_out_t;

  // Line level of one bit position of an 8E2 frame
  function automatic logic frame_bit(input logic [7:0] d, input logic [4:0] pos);
    logic [4:0] k;
    logic       b;
    k = pos - 5'd1;
    if (pos == 5'd0) begin
      b = 1'b0;
    end else if (pos <= 5'd8) begin
      b = d[k[2:0]];
    end else if (pos == 5'd9) begin
      b = ^d;
    end else begin
      b = 1'b1;
    end
    return b;
  endfunction

endpackage

FILE: sv/sync_serial_frame_codec_top.sv
// Top level of the synchronous serial 8E2 frame codec.
//
//  port group   direction  handshake         payload
//  in_*         input      in_valid/ready    ssfc_in_t  (command, tx_data, idle_bits, sample)
//  out_*        output     out_valid/ready   ssfc_out_t (one line bit or rx status per item)
//  cfg_*        input      cfg_we            start hunt limit, 8 bits
//
// A receive item gives one result, send idle one per idle bit (0..32, none for 0),
// send frame 12: the output register emits one result per cycle unless out_ready
// stalls. Receive items can follow each other every cycle without a stall; a new
// item is taken in the cycle that the previous item's last result moves into the
// output register. Reset is synchronous, active low; it clears the receiver and
// sets the limit to 64. A stall holds the output and a busy work register.
`timescale 1ns / 1ps
`include "sync_serial_frame_codec_top_assert.svh"

module sync_serial_frame_codec_top
  import ssfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ssfc_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output ssfc_out_t out_data,
  input  logic      cfg_we,
  input  logic [7:0] cfg_wdata
);

  // Configuration
  logic [7:0] hunt_limit_r;

  // Work register: the item being turned into results
  logic       busy_r;
  logic [1:0] cmd_r;
  logic [7:0] data_r;
  logic       sample_r;
  logic [4:0] pos_r;
  logic [4:0] len_r;

  // Receiver state
  logic [3:0] rx_phase_r, rx_phase_nxt;
  logic [7:0] hunt_count_r, hunt_count_nxt;
  logic [7:0] rx_shift_r, rx_shift_nxt;
  logic       rx_parity_r, rx_parity_nxt;
  logic       parity_bad_r, parity_bad_nxt;
  logic       stop1_r, stop1_nxt;

  // Output register
  logic       out_valid_r;
  ssfc_out_t  out_r;

  logic       adv;
  logic       emit;
  logic       last_now;
  logic       accept;
  logic       send_clear;
  logic [5:0] idle_n;
  logic [8:0] hunt_inc;
  logic [8:0] hunt_lim;
  logic [3:0] data_idx;
  logic [2:0] rx_status;
  logic [7:0] rx_data;
  ssfc_out_t  res;

  assign adv        = !out_valid_r || out_ready;
  assign emit       = busy_r && adv;
  assign last_now   = (pos_r == len_r);
  assign in_ready   = !busy_r || (adv && last_now);
  assign accept     = in_valid && in_ready;
  assign send_clear = accept && ((in_data.command == CMD_IDLE) ||
                                 (in_data.command == CMD_FRAME));
  assign idle_n     = (in_data.idle_bits > MAX_IDLE) ? MAX_IDLE : in_data.idle_bits;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Step the deframer by one sampled bit
  always_comb begin
    rx_phase_nxt   = rx_phase_r;
    hunt_count_nxt = hunt_count_r;
    rx_shift_nxt   = rx_shift_r;
    rx_parity_nxt  = rx_parity_r;
    parity_bad_nxt = parity_bad_r;
    stop1_nxt      = stop1_r;
    rx_status      = ST_BUSY;
    rx_data        = 8'd0;
    hunt_inc       = {1'b0, hunt_count_r} + 9'd1;
    hunt_lim       = (hunt_limit_r == 8'd0) ? 9'd1 : {1'b0, hunt_limit_r};
    data_idx       = rx_phase_r - 4'd1;
    if (rx_phase_r == PH_HUNT) begin
      if (!sample_r) begin
        rx_phase_nxt   = PH_DATA1;
        hunt_count_nxt = 8'd0;
        rx_shift_nxt   = 8'd0;
        rx_parity_nxt  = 1'b0;
      end else if (hunt_inc >= hunt_lim) begin
        rx_status      = ST_TIMEOUT;
        hunt_count_nxt = 8'd0;
        rx_shift_nxt   = 8'd0;
        rx_parity_nxt  = 1'b0;
        parity_bad_nxt = 1'b0;
        stop1_nxt      = 1'b1;
      end else begin
        hunt_count_nxt = hunt_inc[7:0];
      end
    end else if (rx_phase_r <= PH_DATA8) begin
      rx_shift_nxt             = rx_shift_r;
      rx_shift_nxt[data_idx[2:0]] = rx_shift_r[data_idx[2:0]] | sample_r;
      rx_parity_nxt            = rx_parity_r ^ sample_r;
      rx_phase_nxt             = rx_phase_r + 4'd1;
    end else if (rx_phase_r == PH_PARITY) begin
      parity_bad_nxt = (sample_r != rx_parity_r);
      rx_phase_nxt   = PH_STOP1;
    end else if (rx_phase_r == PH_STOP1) begin
      stop1_nxt    = sample_r;
      rx_phase_nxt = PH_STOP2;
    end else begin
      if (parity_bad_r) begin
        rx_status = ST_PARITY;
      end else if (!stop1_r) begin
        rx_status = ST_FRAMING;
      end else begin
        rx_status = ST_OK;
        rx_data   = rx_shift_r;
      end
      rx_phase_nxt   = PH_HUNT;
      hunt_count_nxt = 8'd0;
      rx_shift_nxt   = 8'd0;
      rx_parity_nxt  = 1'b0;
      parity_bad_nxt = 1'b0;
      stop1_nxt      = 1'b1;
    end
  end

  // Form the result for the current position of the work register
  always_comb begin
    res           = '0;
    res.last      = last_now;
    case (cmd_r)
      CMD_IDLE: begin
        res.bit_valid = 1'b1;
        res.line_bit  = 1'b1;
      end
      CMD_FRAME: begin
        res.bit_valid = 1'b1;
        res.line_bit  = frame_bit(data_r, pos_r);
      end
      default: begin
        res.rx_status = rx_status;
        res.rx_data   = rx_data;
      end
    endcase
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hunt_limit_r <= HUNT_LIMIT_RESET;
    end else if (cfg_we) begin
      hunt_limit_r <= cfg_wdata;
    end
  end

  // Load, advance and retire the work register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pos_r  <= 5'd0;
      len_r  <= 5'd0;
    end else if (accept) begin
      cmd_r    <= in_data.command;
      data_r   <= in_data.tx_data;
      sample_r <= in_data.line_sample;
      pos_r    <= 5'd0;
      case (in_data.command)
        CMD_IDLE: begin
          busy_r <= (idle_n != 6'd0);
          len_r  <= idle_n[4:0] - 5'd1;
        end
        CMD_FRAME: begin
          busy_r <= 1'b1;
          len_r  <= FRAME_LAST_POS;
        end
        CMD_RECV: begin
          busy_r <= 1'b1;
          len_r  <= 5'd0;
        end
        default: begin
          busy_r <= 1'b0;
          len_r  <= 5'd0;
        end
      endcase
    end else if (emit) begin
      if (last_now) begin
        busy_r <= 1'b0;
      end else begin
        pos_r <= pos_r + 5'd1;
      end
    end
  end

  // Receiver state: a send item clears it; the clear wins over a receive step in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n || send_clear) begin
      rx_phase_r   <= PH_HUNT;
      hunt_count_r <= 8'd0;
      rx_shift_r   <= 8'd0;
      rx_parity_r  <= 1'b0;
      parity_bad_r <= 1'b0;
      stop1_r      <= 1'b1;
    end else if (emit && (cmd_r == CMD_RECV)) begin
      rx_phase_r   <= rx_phase_nxt;
      hunt_count_r <= hunt_count_nxt;
      rx_shift_r   <= rx_shift_nxt;
      rx_parity_r  <= rx_parity_nxt;
      parity_bad_r <= parity_bad_nxt;
      stop1_r      <= stop1_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= res;
    end
  end

  // Checks
  `SSFC_ASSERT_SAME(a_take_on_last, clk, rst_n, accept && busy_r, emit && last_now)
  `SSFC_ASSERT_SAME(a_pos_in_range, clk, rst_n, busy_r, pos_r <= len_r)
  `SSFC_ASSERT_NEXT(a_stay_busy, clk, rst_n, emit && !last_now, busy_r)
  `SSFC_ASSERT_SAME(a_rx_single, clk, rst_n, out_valid_r && !out_r.bit_valid, out_r.last)

endmodule
